// ----- rtl/sust_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted set table package
// Shared constants, codes and types for the sorted unique set table.
// ----------------------------------------------------------------------------
package sust_pkg;

   localparam int DEFAULT_CAPACITY = 256;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_SEARCH = 2'd3;

   localparam logic [2:0] STATUS_DONE     = 3'd0;
   localparam logic [2:0] STATUS_PRESENT  = 3'd1;
   localparam logic [2:0] STATUS_BADPOS   = 3'd2;
   localparam logic [2:0] STATUS_NOTFOUND = 3'd3;
   localparam logic [2:0] STATUS_FULL     = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_READ_WAIT
   } state_type;

endpackage

// ----- rtl/sorted_unique_set_table.sv -----
// ----------------------------------------------------------------------------
// Sorted unique set table
// Strobe: bad position from idle, read after a RAM read, search after up to
// ceil(log2(count+1)) probes, insert after its search and a read/write per
// entry moved up, remove after one per entry moved down; one request at a time.
// Busy falls with the strobe, which cannot stall; sync reset empties the table.
// ----------------------------------------------------------------------------
module sorted_unique_set_table #(
   parameter int CAPACITY = sust_pkg::DEFAULT_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_position,
   output logic               busy,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic [7:0]         rsp_position_out,
   output logic [8:0]         rsp_entry_count
);
   import sust_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 8) ? CW : 8;
   localparam int YW = (CW > 9) ? CW : 9;

   state_type          state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   logic signed [31:0] value_ff, value_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic               found_ff, found_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [CW-1:0]      count_ff, count_in;

   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff, status_in;
   logic signed [31:0] rsp_value_ff, vout_in;
   logic [7:0]         rsp_position_ff, pout_in;
   logic [8:0]         rsp_count_ff, count_sat;
   logic               fire;

   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic signed [31:0] mem_wdata, mem_rdata;

   logic               lo_lt_hi, pos_ok, shift_more, is_insert;
   logic [CW:0]        mid_sum;
   logic [CW-1:0]      mid;
   logic [AW-1:0]      mid_addr, pos_addr;
   logic [7:0]         lo_sat;
   logic [XW-1:0]      lo_wide;
   logic [YW-1:0]      count_wide;

   sust_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign lo_lt_hi  = lo_ff < hi_ff;
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid       = CW'(mid_sum >> 1);
   assign mid_addr  = mid[AW-1:0];
   assign pos_ok    = XW'(req_position) < XW'(count_ff);
   assign pos_addr  = AW'(req_position);
   assign is_insert = kind_ff == KIND_INSERT;
   assign lo_wide   = XW'(lo_ff);
   assign lo_sat    = (lo_wide > XW'(255)) ? 8'hFF : lo_wide[7:0];

   always_comb begin
      if (is_insert) begin
         shift_more = CW'(ptr_ff) > lo_ff;
      end else begin
         shift_more = (CW'(ptr_ff) + CW'(1)) < count_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_kind)
                  KIND_INSERT, KIND_SEARCH: state_in = ST_SRCH_RD;
                  KIND_READ:   state_in = pos_ok ? ST_READ_WAIT : ST_IDLE;
                  KIND_REMOVE: state_in = pos_ok ? ST_SHIFT_RD : ST_IDLE;
               endcase
            end
         end
         ST_SRCH_RD:   state_in = lo_lt_hi ? ST_SRCH_CMP : ST_DECIDE;
         ST_SRCH_CMP:  state_in = ST_SRCH_RD;
         ST_DECIDE: begin
            if (is_insert && !found_ff && (count_ff < CW'(CAPACITY))) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT_RD:  state_in = shift_more ? ST_SHIFT_WR : ST_IDLE;
         ST_SHIFT_WR:  state_in = ST_SHIFT_RD;
         ST_READ_WAIT: state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      kind_in   = kind_ff;
      value_in  = value_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      found_in  = found_ff;
      ptr_in    = ptr_ff;
      count_in  = count_ff;
      mem_re    = 1'b0;
      mem_raddr = ptr_ff;
      mem_we    = 1'b0;
      mem_waddr = ptr_ff;
      mem_wdata = mem_rdata;
      fire      = 1'b0;
      status_in = STATUS_DONE;
      vout_in   = '0;
      pout_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               value_in = req_value;
               lo_in    = '0;
               hi_in    = count_ff;
               found_in = 1'b0;
               unique case (req_kind)
                  KIND_INSERT, KIND_SEARCH: begin
                  end
                  KIND_READ: begin
                     if (pos_ok) begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_addr;
                     end else begin
                        fire      = 1'b1;
                        status_in = STATUS_BADPOS;
                     end
                  end
                  KIND_REMOVE: begin
                     if (pos_ok) begin
                        ptr_in = pos_addr;
                     end else begin
                        fire      = 1'b1;
                        status_in = STATUS_BADPOS;
                     end
                  end
               endcase
            end
         end
         ST_SRCH_RD: begin
            if (lo_lt_hi) begin
               mem_re    = 1'b1;
               mem_raddr = mid_addr;
            end
         end
         ST_SRCH_CMP: begin
            if (mem_rdata < value_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            if (mem_rdata == value_ff) begin
               found_in = 1'b1;
            end
         end
         ST_DECIDE: begin
            if (!is_insert) begin
               fire = 1'b1;
               if (found_ff) begin
                  pout_in = lo_sat;
               end else begin
                  status_in = STATUS_NOTFOUND;
               end
            end else if (found_ff) begin
               fire      = 1'b1;
               status_in = STATUS_PRESENT;
            end else if (count_ff >= CW'(CAPACITY)) begin
               fire      = 1'b1;
               status_in = STATUS_FULL;
            end else begin
               ptr_in = count_ff[AW-1:0];
            end
         end
         ST_SHIFT_RD: begin
            if (shift_more) begin
               mem_re    = 1'b1;
               mem_raddr = is_insert ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
            end else begin
               fire = 1'b1;
               if (is_insert) begin
                  mem_we    = 1'b1;
                  mem_wdata = value_ff;
                  count_in  = count_ff + CW'(1);
               end else begin
                  count_in  = count_ff - CW'(1);
               end
            end
         end
         ST_SHIFT_WR: begin
            mem_we = 1'b1;
            ptr_in = is_insert ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
         end
         ST_READ_WAIT: begin
            fire    = 1'b1;
            vout_in = mem_rdata;
         end
         default: begin
         end
      endcase
   end

   assign count_wide = YW'(count_in);
   assign count_sat  = (count_wide > YW'(511)) ? 9'h1FF : count_wide[8:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      found_ff <= found_in;
      ptr_ff   <= ptr_in;
      if (fire) begin
         rsp_status_ff   <= status_in;
         rsp_value_ff    <= vout_in;
         rsp_position_ff <= pout_in;
         rsp_count_ff    <= count_sat;
      end
   end

   assign busy             = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_value_out    = rsp_value_ff;
   assign rsp_position_out = rsp_position_ff;
   assign rsp_entry_count  = rsp_count_ff;

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe while a request is still in progress");

   a_accept_progress : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid_ff || busy))
      else $error("accepted request neither answered nor in progress");

   a_count_with_result : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> rsp_valid_ff)
      else $error("entry count changed without a result");

endmodule

// ----- rtl/sust_ram.sv -----
// ----------------------------------------------------------------------------
// Sorted set table storage
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module sust_ram #(
   parameter int DEPTH = sust_pkg::DEFAULT_CAPACITY,
   parameter int AW    = 8
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  logic signed [31:0]   wdata,
   input  logic                 re,
   input  logic [AW-1:0]        raddr,
   output logic signed [31:0]   rdata
);
   import sust_pkg::*;

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- tb/sorted_unique_set_table_tb.sv -----
// ----------------------------------------------------------------------------
// Sorted unique set table testbench
// Drives insert, read, remove and search requests through the start/busy
// port and checks each result strobe against a table kept in the testbench.
// A short directed run covers the edge values and the error answers. Random
// runs under several sender idle rates follow, then a fill to capacity,
// requests at full, and a drain back to empty.
// ----------------------------------------------------------------------------
module sorted_unique_set_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sust_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int DRAIN_CYCLES = 600;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   typedef struct {
      logic [1:0]         kind;
      logic signed [31:0] value;
      logic [7:0]         position;
      int                 idle_pct;
   } set_req_type;

   typedef struct {
      logic [2:0]         status;
      logic signed [31:0] value_out;
      logic [7:0]         position_out;
      logic [8:0]         entry_count;
   } set_rsp_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [1:0]         req_kind = KIND_READ;
   logic signed [31:0] req_value = '0;
   logic [7:0]         req_position = '0;
   logic               busy;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_value_out;
   logic [7:0]         rsp_position_out;
   logic [8:0]         rsp_entry_count;

   set_req_type        queued_ops[$];
   set_rsp_type        predicted_answers[$];
   set_req_type        next_op;
   set_rsp_type        due_answer;

   logic signed [31:0] set_vals [CAPACITY];
   int                 set_count = 0;
   int                 peak_count = 0;
   int                 kind_seen [4];
   int                 status_seen [5];
   int                 sender_idle_pct = 0;
   int                 errors = 0;
   int                 answers_checked = 0;
   int                 cycle_count = 0;

   sorted_unique_set_table #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_kind(req_kind),
      .req_value(req_value),
      .req_position(req_position),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_value_out(rsp_value_out),
      .rsp_position_out(rsp_position_out),
      .rsp_entry_count(rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int first_not_below(input logic signed [31:0] v);
      int i;
      i = 0;
      while (i < set_count && set_vals[i] < v) i++;
      return i;
   endfunction

   function automatic void apply_set_op(input logic [1:0] kind,
                                        input logic signed [31:0] v,
                                        input logic [7:0] pos);
      set_rsp_type r;
      int idx;
      r.status = STATUS_DONE;
      r.value_out = '0;
      r.position_out = '0;
      case (kind)
         KIND_INSERT: begin
            idx = first_not_below(v);
            if (idx < set_count && set_vals[idx] == v) begin
               r.status = STATUS_PRESENT;
            end else if (set_count >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               for (int j = set_count; j > idx; j--) set_vals[j] = set_vals[j - 1];
               set_vals[idx] = v;
               set_count++;
            end
         end
         KIND_READ: begin
            if (pos >= set_count) r.status = STATUS_BADPOS;
            else r.value_out = set_vals[pos];
         end
         KIND_REMOVE: begin
            if (pos >= set_count) begin
               r.status = STATUS_BADPOS;
            end else begin
               for (int j = pos; j < set_count - 1; j++) set_vals[j] = set_vals[j + 1];
               set_count--;
            end
         end
         default: begin
            idx = first_not_below(v);
            if (idx < set_count && set_vals[idx] == v) r.position_out = 8'(idx);
            else r.status = STATUS_NOTFOUND;
         end
      endcase
      r.entry_count = 9'(set_count);
      if (set_count > peak_count) peak_count = set_count;
      kind_seen[kind]++;
      status_seen[r.status]++;
      predicted_answers.push_back(r);
   endfunction

   // A beat is taken when start is high and busy is low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) apply_set_op(req_kind, req_value, req_position);
         if (!start || !busy) begin
            if (queued_ops.size() != 0 &&
                $urandom_range(99) >= queued_ops[0].idle_pct) begin
               next_op = queued_ops.pop_front();
               start <= 1'b1;
               req_kind <= next_op.kind;
               req_value <= next_op.value;
               req_position <= next_op.position;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (predicted_answers.size() == 0) begin
            $display("%0t: result with nothing expected: status %0d value %0d",
                     $time, rsp_status, rsp_value_out);
            errors++;
         end else begin
            due_answer = predicted_answers.pop_front();
            answers_checked++;
            if (rsp_status !== due_answer.status) begin
               $display("%0t: status expected %0d, actual %0d",
                        $time, due_answer.status, rsp_status);
               errors++;
            end
            if (rsp_value_out !== due_answer.value_out) begin
               $display("%0t: value_out expected %0d, actual %0d",
                        $time, due_answer.value_out, rsp_value_out);
               errors++;
            end
            if (rsp_position_out !== due_answer.position_out) begin
               $display("%0t: position_out expected %0d, actual %0d",
                        $time, due_answer.position_out, rsp_position_out);
               errors++;
            end
            if (rsp_entry_count !== due_answer.entry_count) begin
               $display("%0t: entry_count expected %0d, actual %0d",
                        $time, due_answer.entry_count, rsp_entry_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding",
                  $time, predicted_answers.size());
         $display("sorted_unique_set_table_tb NOT OK");
         $finish;
      end
   end

   task automatic queue_req(input logic [1:0] kind, input logic signed [31:0] v,
                            input logic [7:0] pos);
      set_req_type op;
      op.kind = kind;
      op.value = v;
      op.position = pos;
      op.idle_pct = sender_idle_pct;
      queued_ops.push_back(op);
   endtask

   task automatic wait_slot();
      while (queued_ops.size() != 0 || start) @(negedge clock);
   endtask

   task automatic make_item(input int target);
      int roll;
      int pick;
      logic [1:0] kind;
      logic signed [31:0] v;
      logic [7:0] pos;
      wait_slot();
      roll = $urandom_range(99);
      if (set_count < target) begin
         kind = roll < 55 ? KIND_INSERT : roll < 65 ? KIND_REMOVE :
                roll < 80 ? KIND_READ : KIND_SEARCH;
      end else if (set_count > target) begin
         kind = roll < 20 ? KIND_INSERT : roll < 65 ? KIND_REMOVE :
                roll < 80 ? KIND_READ : KIND_SEARCH;
      end else begin
         kind = roll < 25 ? KIND_INSERT : roll < 50 ? KIND_READ :
                roll < 75 ? KIND_REMOVE : KIND_SEARCH;
      end
      pick = $urandom_range(99);
      if (set_count != 0 && pick < 40) begin
         v = set_vals[$urandom_range(set_count - 1)];
      end else if (set_count != 0 && pick < 50) begin
         v = set_vals[$urandom_range(set_count - 1)];
         v = pick[0] ? v + 32'sd1 : v - 32'sd1;
      end else if (pick < 58) begin
         case ($urandom_range(3))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = '0;
            default: v = -32'sd1;
         endcase
      end else begin
         v = $urandom;
      end
      pick = $urandom_range(99);
      if (set_count != 0 && pick < 70) pos = 8'($urandom_range(set_count - 1));
      else if (pick < 85) pos = 8'(set_count);
      else pos = 8'($urandom_range(255));
      queue_req(kind, v, pos);
   endtask

   initial begin
      int phase_idle [3];
      int targets [5];
      int target;
      phase_idle = '{0, 75, 12};
      targets = '{2, 8, 32, 96, 160};
      foreach (kind_seen[k]) kind_seen[k] = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
      foreach (set_vals[i]) set_vals[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_req(KIND_READ, '0, 8'd0);
      queue_req(KIND_REMOVE, '0, 8'd0);
      queue_req(KIND_SEARCH, '0, 8'd0);
      queue_req(KIND_INSERT, '0, 8'd0);
      queue_req(KIND_INSERT, VAL_MAX, 8'd255);
      queue_req(KIND_INSERT, VAL_MIN, 8'd0);
      queue_req(KIND_INSERT, -32'sd1, 8'd0);
      queue_req(KIND_INSERT, 32'sd1, 8'd0);
      queue_req(KIND_INSERT, VAL_MAX, 8'd0);
      queue_req(KIND_INSERT, VAL_MIN, 8'd0);
      queue_req(KIND_READ, '0, 8'd0);
      queue_req(KIND_READ, '0, 8'd4);
      queue_req(KIND_READ, '0, 8'd5);
      queue_req(KIND_READ, VAL_MAX, 8'd255);
      queue_req(KIND_SEARCH, VAL_MIN, 8'd0);
      queue_req(KIND_SEARCH, VAL_MAX, 8'd0);
      queue_req(KIND_SEARCH, 32'sd2, 8'd0);
      queue_req(KIND_SEARCH, VAL_MIN + 32'sd1, 8'd0);
      queue_req(KIND_REMOVE, '0, 8'd2);
      queue_req(KIND_REMOVE, '0, 8'd3);
      queue_req(KIND_REMOVE, '0, 8'd0);
      queue_req(KIND_READ, '0, 8'd1);
      queue_req(KIND_REMOVE, '0, 8'd255);
      queue_req(KIND_REMOVE, '0, 8'd1);
      queue_req(KIND_REMOVE, '0, 8'd0);

      target = 0;
      foreach (phase_idle[ph]) begin
         sender_idle_pct = phase_idle[ph];
         for (int n = 0; n < 350; n++) begin
            if (n % 50 == 0) target = targets[$urandom_range(4)];
            make_item(target);
         end
      end

      sender_idle_pct = 0;
      wait_slot();
      while (set_count < CAPACITY) begin
         queue_req(KIND_INSERT, $urandom, 8'($urandom_range(255)));
         wait_slot();
      end
      sender_idle_pct = 75;
      for (int n = 0; n < 40; n++) begin
         wait_slot();
         if (set_count < CAPACITY) queue_req(KIND_INSERT, $urandom, 8'($urandom_range(255)));
         else make_item(CAPACITY);
      end
      sender_idle_pct = 12;
      wait_slot();
      while (set_count > 0) begin
         queue_req(KIND_REMOVE, $urandom, 8'($urandom_range(set_count - 1)));
         wait_slot();
      end

      wait_slot();
      while (predicted_answers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d results: %0d inserts, %0d reads, %0d removes, %0d searches.",
               answers_checked, kind_seen[KIND_INSERT], kind_seen[KIND_READ],
               kind_seen[KIND_REMOVE], kind_seen[KIND_SEARCH]);
      $display("Answers seen: %0d full, %0d duplicate, %0d bad position, %0d misses; peak %0d.",
               status_seen[STATUS_FULL], status_seen[STATUS_PRESENT],
               status_seen[STATUS_BADPOS], status_seen[STATUS_NOTFOUND], peak_count);
      if (errors == 0) begin
         $display("sorted_unique_set_table_tb OK");
      end else begin
         $display("sorted_unique_set_table_tb NOT OK");
      end
      $finish;
   end

endmodule
